[hw/rtl/blur3_pkg.sv]
package blur3_pkg;

  // one rgb pixel, red in the low byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_e;

  localparam int unsigned DIM_W      = 9;
  localparam int unsigned MIN_DIM    = 3;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  // floor of the mean of eight neighbours
  function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d,
                                      input logic [7:0] e, input logic [7:0] f,
                                      input logic [7:0] g, input logic [7:0] h);
    logic [10:0] sum;
    sum = 11'(a) + 11'(b) + 11'(c) + 11'(d) + 11'(e) + 11'(f) + 11'(g) + 11'(h);
    return sum[10:3];
  endfunction

endpackage

[hw/rtl/neighbour_average_blur_3x3_unit.sv]
// 3x3 neighbour-average blur for an rgb pixel stream. pixels of a frame enter in
// raster order, one beat per clock; every interior pixel leaves as the floor of
// the mean of its eight neighbours per channel (centre excluded), and pixels of
// the first/last row or column pass through unchanged. results trail the input
// by one row plus one pixel, so after the last pixel of a frame the source sends
// the clamped frame width plus one drain beats (tuser set) to flush them; the
// final result of the frame has tlast set. one beat is accepted every clock as
// long as the output register is free or being emptied; a result is registered
// into it by the beat that produces it. two line stores of MAX_WIDTH entries
// (one write and one registered read each per clock, read ahead at the next
// column) and a 3x3 window of registers carry the neighbourhood. writing either
// dimension register restarts the frame. a pixel beat after the frame has
// finished starts the next frame; a drain beat outside the flush is dropped.
module neighbour_average_blur_3x3_unit #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // pixel input; tdata: red, green, blue; tuser: req_type
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  // result output; tdata: out_red, out_green, out_blue; tlast: frame_done
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);        // column / line store address
  localparam int unsigned WW   = CW + 1;                   // holds the width itself
  localparam int unsigned CMPW = (WW > blur3_pkg::DIM_W) ? WW : blur3_pkg::DIM_W;
  localparam int unsigned DW   = blur3_pkg::DIM_W;

  // configuration registers
  logic [DW-1:0] frame_width;
  logic [DW-1:0] frame_height;

  // line stores and their read-ahead registers
  blur3_pkg::pix_t older_line [MAX_WIDTH];
  blur3_pkg::pix_t newer_line [MAX_WIDTH];
  blur3_pkg::pix_t rd_top;
  blur3_pkg::pix_t rd_mid;
  logic [CW-1:0]   rd_addr;

  // window, [row][col], col 2 is the newest column
  blur3_pkg::pix_t win      [3][3];
  blur3_pkg::pix_t win_next [3][3];

  // input and output position counters
  logic [CW-1:0] input_column;
  logic [DW-1:0] input_row;
  logic [CW-1:0] out_col;
  logic [DW-1:0] out_row;
  logic          frame_done;   // last result of the frame has been produced

  // output register
  logic            out_valid;
  blur3_pkg::pix_t out_pix;
  logic            out_last;

  // effective dimensions after clamping
  logic [CMPW-1:0] fw_ext;
  logic [WW-1:0]   w_eff;
  logic [DW-1:0]   h_eff;

  always_comb begin
    fw_ext = CMPW'(frame_width);
    if (fw_ext < CMPW'(blur3_pkg::MIN_DIM)) begin
      w_eff = WW'(blur3_pkg::MIN_DIM);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_ext);
    end
    if (frame_height < DW'(blur3_pkg::MIN_DIM)) begin
      h_eff = DW'(blur3_pkg::MIN_DIM);
    end else if (frame_height > DW'(blur3_pkg::MAX_HEIGHT)) begin
      h_eff = DW'(blur3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // beat decode
  logic            s_fire;
  logic            is_drain;
  blur3_pkg::pix_t in_pix;
  logic            restart;      // pixel after a finished frame opens a new one
  logic [CW-1:0]   col_eff;
  logic [DW-1:0]   row_eff;
  logic [CW-1:0]   ocol_eff;
  logic [DW-1:0]   orow_eff;
  logic            feeding;
  logic            step;         // beat advances the stream
  logic            col_last;
  logic [CW-1:0]   col_inc;
  logic [DW-1:0]   row_inc;
  logic            emit;
  logic            ocol_last;
  logic            interior;
  logic            last_pix;
  blur3_pkg::pix_t bot;
  blur3_pkg::pix_t res_pix;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign is_drain      = (blur3_pkg::req_e'(s_axis_tuser[0]) == blur3_pkg::REQ_DRAIN);
  assign in_pix        = blur3_pkg::pix_t'(s_axis_tdata);

  assign restart  = frame_done && !is_drain;
  assign col_eff  = restart ? '0 : input_column;
  assign row_eff  = restart ? '0 : input_row;
  assign ocol_eff = restart ? '0 : out_col;
  assign orow_eff = restart ? '0 : out_row;
  assign feeding  = row_eff < h_eff;

  // drain beats count only once the frame is fully in and not yet flushed
  assign step = s_fire && (!is_drain || (!frame_done && !feeding));

  assign col_last = (WW'(col_eff) + WW'(1)) == w_eff;
  assign col_inc  = col_last ? '0 : col_eff + CW'(1);
  assign row_inc  = row_eff + DW'(col_last);

  // nothing leaves until one row plus one pixel has entered
  assign emit = step && !((row_eff == '0) || (row_eff == DW'(1) && col_eff == '0));

  assign ocol_last = (WW'(ocol_eff) + WW'(1)) == w_eff;
  assign interior  = (orow_eff != '0) && (orow_eff < h_eff - DW'(1)) &&
                     (ocol_eff != '0) && !ocol_last;
  assign last_pix  = (orow_eff == h_eff - DW'(1)) && ocol_last;

  assign bot = feeding ? in_pix : '0;

  // window shift, cleared first on a frame restart
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = restart ? '0 : win[r][1];
      win_next[r][1] = restart ? '0 : win[r][2];
    end
    win_next[0][2] = rd_top;
    win_next[1][2] = rd_mid;
    win_next[2][2] = bot;
  end

  always_comb begin
    if (interior) begin
      res_pix.red   = blur3_pkg::avg8(win_next[0][0].red,   win_next[0][1].red,
                                      win_next[0][2].red,   win_next[1][0].red,
                                      win_next[1][2].red,   win_next[2][0].red,
                                      win_next[2][1].red,   win_next[2][2].red);
      res_pix.green = blur3_pkg::avg8(win_next[0][0].green, win_next[0][1].green,
                                      win_next[0][2].green, win_next[1][0].green,
                                      win_next[1][2].green, win_next[2][0].green,
                                      win_next[2][1].green, win_next[2][2].green);
      res_pix.blue  = blur3_pkg::avg8(win_next[0][0].blue,  win_next[0][1].blue,
                                      win_next[0][2].blue,  win_next[1][0].blue,
                                      win_next[1][2].blue,  win_next[2][0].blue,
                                      win_next[2][1].blue,  win_next[2][2].blue);
    end else begin
      // border pixel passes through
      res_pix = win_next[1][1];
    end
  end

  // read ahead at the column the next beat will use
  always_comb begin
    if (cfg_we) begin
      rd_addr = '0;
    end else if (step) begin
      rd_addr = col_inc;
    end else begin
      rd_addr = input_column;
    end
  end

  // line stores: write the current column, read the next one
  always_ff @(posedge clk) begin
    if (step && feeding) begin
      older_line[col_eff] <= rd_mid;
      newer_line[col_eff] <= in_pix;
    end
    rd_top <= older_line[rd_addr];
    rd_mid <= newer_line[rd_addr];
  end

  // configuration and stream control
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= blur3_pkg::DIM_RESET;
      frame_height <= blur3_pkg::DIM_RESET;
      input_column <= '0;
      input_row    <= '0;
      out_col      <= '0;
      out_row      <= '0;
      frame_done   <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (cfg_we) begin
      case (blur3_pkg::cfg_reg_e'(cfg_index))
        blur3_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        blur3_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
      // any register write restarts the frame
      input_column <= '0;
      input_row    <= '0;
      out_col      <= '0;
      out_row      <= '0;
      frame_done   <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (step) begin
      input_column <= col_inc;
      input_row    <= row_inc;
      win          <= win_next;
      if (restart) begin
        frame_done <= 1'b0;
        out_col    <= '0;
        out_row    <= '0;
      end
      if (emit) begin
        out_col    <= ocol_last ? '0 : ocol_eff + CW'(1);
        out_row    <= orow_eff + DW'(ocol_last);
        frame_done <= last_pix;
      end
    end
  end

  // output register, refilled while the old beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pix  <= res_pix;
      out_last <= last_pix;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_pix;
  assign m_axis_tlast  = out_last;

  // a finished frame has taken exactly one row plus one pixel of drain
  a_done_position: assert property (@(posedge clk) disable iff (rst)
    frame_done |-> (input_row == h_eff + DW'(1)) && (input_column == CW'(1)))
    else $error("frame finished at unexpected input position");

  // the input column never runs past the row
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    WW'(input_column) < w_eff)
    else $error("input column beyond frame width");

  // a flagged last beat only follows the end of the frame
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> frame_done)
    else $error("last beat shown before frame completion");

  // results never outrun the pixels that produce them
  a_out_behind_in: assert property (@(posedge clk) disable iff (rst)
    (out_row <= h_eff) && (out_row <= input_row))
    else $error("output position ahead of input");

endmodule
